@@ rtl/pfbm_pkg.sv @@
// Shared types, constants and helpers for the fBm Perlin noise pixel core.
package pfbm_pkg;

   localparam int TABLE_SIZE   = 256;
   localparam int TBL_AW       = $clog2(TABLE_SIZE);
   localparam int MAX_OCTAVES  = 8;
   localparam int COORD_BITS   = 12;

   localparam int CSR_IDX_W    = 8;
   localparam int CSR_DATA_W   = 24;
   localparam int GRAY_W       = 8;

   localparam int SCALE_W      = 24;
   localparam int OCTCFG_W     = 4;
   localparam int PERS_W       = 17;
   localparam int LAC_W        = 16;
   localparam int FREQ_W       = 24;
   localparam int AMP_W        = 17;

   localparam int MUL_W        = 25;
   localparam int PROD_W       = 2 * MUL_W;

   localparam logic [SCALE_W-1:0]  SCALE_RST = 24'd1311;
   localparam logic [OCTCFG_W-1:0] OCT_RST   = 4'd4;
   localparam logic [PERS_W-1:0]   PERS_RST  = 17'd32768;
   localparam logic [LAC_W-1:0]    LAC_RST   = 16'd8192;

   localparam logic [FREQ_W-1:0]   FREQ_ONE  = 24'd65536;
   localparam logic [AMP_W-1:0]    AMP_ONE   = 17'd65536;
   localparam logic [AMP_W-1:0]    AMP_MAX   = 17'h1FFFF;
   localparam logic [FREQ_W-1:0]   FREQ_MAX  = 24'hFFFFFF;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COORD_SCALE  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_COUNT = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSISTENCE  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LACUNARITY   = 8'd3;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DIV,
      ST_OUT
   } state_type;

   // micro-op list; each op has an issue phase followed by a writeback phase
   typedef enum logic [4:0] {
      OP_BX,   OP_BY,
      OP_CXL,  OP_CXH,  OP_CYL,  OP_CYH,
      OP_RPA,  OP_RPB,  OP_RAA,  OP_RAB,  OP_RBA,  OP_RBB,
      OP_FXTT, OP_FXT3, OP_FXP,  OP_FXU,
      OP_FYTT, OP_FYT3, OP_FYP,  OP_FYV,
      OP_LLO,  OP_LHI,  OP_LN,
      OP_WSUM, OP_AMP,  OP_FREQ
   } op_type;

   // 2D gradient: hash selects axis order and signs; x, y are Q2.16
   function automatic logic signed [18:0] grad_q16(input logic [2:0] h,
                                                   input logic signed [17:0] x,
                                                   input logic signed [17:0] y);
      logic signed [18:0] u;
      logic signed [18:0] v;
      u = h[2] ? 19'(y) : 19'(x);
      v = h[2] ? 19'(x) : 19'(y);
      if (h[0]) u = -u;
      if (h[1]) v = -v;
      return u + v;
   endfunction

endpackage

@@ rtl/perlin_fbm_noise_pixel_core.sv @@
// Top level: fBm Perlin noise gray pixel core with a shared multiplier sequencer.
//
//  channel | ports                                   | direction | role
//  --------+-----------------------------------------+-----------+------------------------
//  req     | req_valid/ready, kind, perm_*, pixel_*  | in        | table load or pixel item
//  rsp     | rsp_valid/ready, rsp_gray               | out       | one gray byte per pixel
//  csr     | csr_valid/ready, csr_index, csr_data    | in        | config register writes
//
// A load item writes the permutation table in its accept cycle; the core stays ready.
// A pixel item runs 24 ops per octave for N octaves, N = clamped octave count: each
// multiply on the single 25x25 multiplier has an issue and a writeback phase, and
// a one-bit-per-cycle divider follows the last octave.
// Reset (synchronous, active high) clears the sequencer, output valid and the
// config registers; the table holds no reset value and must be loaded before use.
// A finished gray byte waits in the output register; the core goes back to idle
// and takes the next item as soon as that register is free.
module perlin_fbm_noise_pixel_core
   import pfbm_pkg::*;
#(
   parameter int MAX_OCT = pfbm_pkg::MAX_OCTAVES,
   parameter int CRD_W   = pfbm_pkg::COORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // item input
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [TBL_AW-1:0]     req_perm_index,
   input  logic [7:0]            req_perm_value,
   input  logic [CRD_W-1:0]      req_pixel_x,
   input  logic [CRD_W-1:0]      req_pixel_y,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [GRAY_W-1:0]     rsp_gray,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int BX_W    = CRD_W + SCALE_W;      // pixel * scale
   localparam int OCT_W   = $clog2(MAX_OCT + 1);
   localparam int SUM_W   = 23 + OCT_W;
   localparam int MAXV_W  = AMP_W + OCT_W;
   localparam int NUM_W   = SUM_W + 16;
   localparam int REM_W   = MAXV_W + 1;
   localparam int DCNT_W  = $clog2(NUM_W);

   // ---------------- config registers ----------------
   logic [SCALE_W-1:0]  coord_scale_ff;
   logic [OCTCFG_W-1:0] octave_count_ff;
   logic [PERS_W-1:0]   persistence_ff;
   logic [LAC_W-1:0]    lacunarity_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_scale_ff  <= SCALE_RST;
         octave_count_ff <= OCT_RST;
         persistence_ff  <= PERS_RST;
         lacunarity_ff   <= LAC_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COORD_SCALE:  coord_scale_ff  <= csr_data[SCALE_W-1:0];
            CSR_OCTAVE_COUNT: octave_count_ff <= csr_data[OCTCFG_W-1:0];
            CSR_PERSISTENCE:  persistence_ff  <= csr_data[PERS_W-1:0];
            CSR_LACUNARITY:   lacunarity_ff   <= csr_data[LAC_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- control state ----------------
   state_type state_ff, state_in;
   op_type    op_ff;
   logic      phase_ff;                 // 0 = issue, 1 = writeback
   logic [OCT_W-1:0]  oct_ff;
   logic [OCT_W-1:0]  oct_n_ff;         // clamped octave count
   logic [DCNT_W-1:0] dcnt_ff;
   logic              rsp_valid_ff;
   logic [GRAY_W-1:0] rsp_gray_ff;

   logic req_take, pix_take, load_take, last_oct, out_free, div_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign pix_take  = req_take && (req_kind == KIND_PIXEL);
   assign load_take = req_take && (req_kind == KIND_LOAD);
   assign last_oct  = (oct_ff == oct_n_ff - OCT_W'(1));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign div_last  = (dcnt_ff == DCNT_W'(NUM_W - 1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_gray  = rsp_gray_ff;

   // octave count clamp: zero counts as one, above the limit counts as the limit
   logic [OCT_W-1:0] oct_clamp;
   always_comb begin
      if (octave_count_ff == '0)
         oct_clamp = OCT_W'(1);
      else if ({1'b0, octave_count_ff} > 5'(MAX_OCT))
         oct_clamp = OCT_W'(MAX_OCT);
      else
         oct_clamp = OCT_W'(octave_count_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (pix_take) state_in = ST_RUN;
         ST_RUN:  if (phase_ff && op_ff == OP_FREQ && last_oct) state_in = ST_DIV;
         ST_DIV:  if (div_last) state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_BX;
         phase_ff     <= 1'b0;
         oct_ff       <= '0;
         oct_n_ff     <= OCT_W'(1);
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_OUT && out_free) || (rsp_valid_ff && !rsp_ready);
         case (state_ff)
            ST_IDLE: begin
               if (pix_take) begin
                  op_ff    <= OP_BX;
                  phase_ff <= 1'b0;
                  oct_ff   <= '0;
                  oct_n_ff <= oct_clamp;
               end
            end
            ST_RUN: begin
               phase_ff <= !phase_ff;
               if (phase_ff) begin
                  if (op_ff == OP_FREQ) begin
                     op_ff   <= OP_CXL;
                     oct_ff  <= oct_ff + OCT_W'(1);
                     dcnt_ff <= '0;
                  end else begin
                     op_ff <= op_type'(op_ff + 5'd1);
                  end
               end
            end
            ST_DIV: dcnt_ff <= dcnt_ff + DCNT_W'(1);
            default: ;
         endcase
      end
   end

   // ---------------- permutation table ----------------
   logic [7:0]        perm_mem [TABLE_SIZE];
   logic [TBL_AW-1:0] rd_addr;
   logic [7:0]        rd_ff;

   always_ff @(posedge clock) begin
      if (load_take) perm_mem[req_perm_index] <= req_perm_value;
      rd_ff <= perm_mem[rd_addr];
   end

   // ---------------- datapath registers ----------------
   logic [CRD_W-1:0]   px_ff, py_ff;
   logic [BX_W-1:0]    bx_ff, by_ff;
   logic [39:0]        cacc_ff;
   logic [23:0]        cx_ff, cy_ff;
   logic [7:0]         pa_ff, pb_ff;
   logic signed [18:0] g_aa_ff, g_ab_ff;
   logic signed [19:0] dlo_ff, dhi_ff, dn_ff;
   logic [15:0]        tt_ff, t3_ff;
   logic [19:0]        q_ff;
   logic [16:0]        u_ff, v_ff;
   logic signed [18:0] lo_ff, noise_ff;
   logic [FREQ_W-1:0]  freq_ff;
   logic [AMP_W-1:0]   amp_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [MAXV_W-1:0]  maxv_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [NUM_W-1:0]   num_ff;       // dividend, shifted into quotient
   logic [REM_W-1:0]   rem_ff;
   logic               neg_ff;

   // shared multiplier operands
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic [15:0] t_sel;
   logic [20:0] c6;

   // fractional offsets to the lower and upper lattice corners
   logic signed [17:0] x0, x1, y0, y1;
   assign x0 = $signed({2'b00, cx_ff[15:0]});
   assign y0 = $signed({2'b00, cy_ff[15:0]});
   assign x1 = x0 - 18'sd65536;
   assign y1 = y0 - 18'sd65536;

   logic [39:0] csum;
   assign csum = cacc_ff + {prod_ff[21:0], 18'd0};

   logic signed [19:0] psh;          // floor(prod / 2^16), lerp range
   assign psh = $signed(prod_ff[35:16]);

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      rd_addr = cx_ff[23:16];
      t_sel   = (op_ff == OP_FYTT || op_ff == OP_FYT3 || op_ff == OP_FYP || op_ff == OP_FYV)
                ? cy_ff[15:0] : cx_ff[15:0];
      c6      = 21'd983040 - ({5'd0, t_sel} << 2) - ({5'd0, t_sel} << 1);
      case (op_ff)
         OP_BX:   begin mul_a = MUL_W'($signed({1'b0, px_ff}));
                        mul_b = MUL_W'($signed({1'b0, coord_scale_ff})); end
         OP_BY:   begin mul_a = MUL_W'($signed({1'b0, py_ff}));
                        mul_b = MUL_W'($signed({1'b0, coord_scale_ff})); end
         OP_CXL:  begin mul_a = MUL_W'($signed({1'b0, bx_ff[17:0]}));
                        mul_b = MUL_W'($signed({1'b0, freq_ff})); end
         OP_CXH:  begin mul_a = MUL_W'($signed({1'b0, bx_ff[BX_W-1:18]}));
                        mul_b = MUL_W'($signed({1'b0, freq_ff})); end
         OP_CYL:  begin mul_a = MUL_W'($signed({1'b0, by_ff[17:0]}));
                        mul_b = MUL_W'($signed({1'b0, freq_ff})); end
         OP_CYH:  begin mul_a = MUL_W'($signed({1'b0, by_ff[BX_W-1:18]}));
                        mul_b = MUL_W'($signed({1'b0, freq_ff})); end
         OP_RPA:  rd_addr = cx_ff[23:16];
         OP_RPB:  rd_addr = cx_ff[23:16] + 8'd1;
         OP_RAA:  rd_addr = pa_ff + cy_ff[23:16];
         OP_RAB:  rd_addr = pa_ff + cy_ff[23:16] + 8'd1;
         OP_RBA:  rd_addr = pb_ff + cy_ff[23:16];
         OP_RBB:  rd_addr = pb_ff + cy_ff[23:16] + 8'd1;
         OP_FXTT, OP_FYTT: begin
                        mul_a = MUL_W'($signed({1'b0, t_sel}));
                        mul_b = MUL_W'($signed({1'b0, t_sel})); end
         OP_FXT3, OP_FYT3: begin
                        mul_a = MUL_W'($signed({1'b0, tt_ff}));
                        mul_b = MUL_W'($signed({1'b0, t_sel})); end
         OP_FXP, OP_FYP: begin
                        mul_a = MUL_W'($signed({1'b0, t_sel}));
                        mul_b = MUL_W'($signed({1'b0, c6})); end
         OP_FXU, OP_FYV: begin
                        mul_a = MUL_W'($signed({1'b0, t3_ff}));
                        mul_b = MUL_W'($signed({1'b0, q_ff})); end
         OP_LLO:  begin mul_a = MUL_W'($signed({1'b0, u_ff})); mul_b = MUL_W'(dlo_ff); end
         OP_LHI:  begin mul_a = MUL_W'($signed({1'b0, u_ff})); mul_b = MUL_W'(dhi_ff); end
         OP_LN:   begin mul_a = MUL_W'($signed({1'b0, v_ff})); mul_b = MUL_W'(dn_ff); end
         OP_WSUM: begin mul_a = MUL_W'(noise_ff);
                        mul_b = MUL_W'($signed({1'b0, amp_ff})); end
         OP_AMP:  begin mul_a = MUL_W'($signed({1'b0, amp_ff}));
                        mul_b = MUL_W'($signed({1'b0, persistence_ff})); end
         OP_FREQ: begin mul_a = MUL_W'($signed({1'b0, freq_ff}));
                        mul_b = MUL_W'($signed({1'b0, lacunarity_ff})); end
         default: ;
      endcase
   end

   // restoring divider step
   logic [REM_W-1:0] rem_sh, rem_sub;
   logic             qbit;
   assign rem_sh  = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
   assign rem_sub = rem_sh - {1'b0, maxv_ff};
   assign qbit    = (rem_sh >= {1'b0, maxv_ff});

   logic [SUM_W-1:0] sum_mag;
   assign sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   // map quotient in [-1,1] Q.16 to a gray byte; big magnitudes saturate early
   logic [18:0]        qs;
   logic signed [20:0] sval;
   logic signed [21:0] wv;
   logic signed [29:0] gnum;
   logic [GRAY_W-1:0]  gray_val;

   always_comb begin
      qs   = (|num_ff[NUM_W-1:19]) ? 19'h7FFFF : num_ff[18:0];
      sval = neg_ff ? -$signed({2'b00, qs}) : $signed({2'b00, qs});
      wv   = 22'(sval) + 22'sd65536;
      gnum = (30'(wv) <<< 8) - 30'(wv);
      if (gnum <= 30'sd0)
         gray_val = '0;
      else if (|gnum[29:25])
         gray_val = 8'd255;
      else
         gray_val = gnum[24:17];
   end

   always_ff @(posedge clock) begin
      if (pix_take) begin
         px_ff   <= req_pixel_x;
         py_ff   <= req_pixel_y;
         freq_ff <= FREQ_ONE;
         amp_ff  <= AMP_ONE;
         sum_ff  <= '0;
         maxv_ff <= '0;
      end
      if (state_ff == ST_RUN && !phase_ff)
         prod_ff <= mul_a * mul_b;
      if (state_ff == ST_RUN && phase_ff) begin
         case (op_ff)
            OP_BX:   bx_ff   <= prod_ff[BX_W-1:0];
            OP_BY:   by_ff   <= prod_ff[BX_W-1:0];
            OP_CXL, OP_CYL: cacc_ff <= prod_ff[39:0];
            OP_CXH:  cx_ff   <= csum[39:16];
            OP_CYH:  cy_ff   <= csum[39:16];
            OP_RPA:  pa_ff   <= rd_ff;
            OP_RPB:  pb_ff   <= rd_ff;
            OP_RAA:  g_aa_ff <= grad_q16(rd_ff[2:0], x0, y0);
            OP_RAB:  g_ab_ff <= grad_q16(rd_ff[2:0], x0, y1);
            OP_RBA:  dlo_ff  <= 20'(grad_q16(rd_ff[2:0], x1, y0)) - 20'(g_aa_ff);
            OP_RBB:  dhi_ff  <= 20'(grad_q16(rd_ff[2:0], x1, y1)) - 20'(g_ab_ff);
            OP_FXTT, OP_FYTT: tt_ff <= prod_ff[31:16];
            OP_FXT3, OP_FYT3: t3_ff <= prod_ff[31:16];
            OP_FXP, OP_FYP:   q_ff  <= 20'd655360 - prod_ff[35:16];
            OP_FXU:  u_ff    <= prod_ff[32:16];
            OP_FYV:  v_ff    <= prod_ff[32:16];
            OP_LLO:  lo_ff   <= 19'(20'(g_aa_ff) + psh);
            OP_LHI:  dn_ff   <= (20'(g_ab_ff) + psh) - 20'(lo_ff);
            OP_LN:   noise_ff <= 19'(20'(lo_ff) + psh);
            OP_WSUM: begin
               sum_ff  <= sum_ff + SUM_W'(psh);
               maxv_ff <= maxv_ff + MAXV_W'(amp_ff);
            end
            OP_AMP:  amp_ff  <= prod_ff[33] ? AMP_MAX : prod_ff[32:16];
            OP_FREQ: begin
               freq_ff <= (|prod_ff[39:36]) ? FREQ_MAX : prod_ff[35:12];
               // set up the divider at every octave end; the last octave's setup is the one used
               num_ff  <= {sum_mag, 16'd0};
               rem_ff  <= '0;
               neg_ff  <= sum_ff[SUM_W-1];
            end
            default: ;
         endcase
      end
      if (state_ff == ST_DIV) begin
         rem_ff <= qbit ? rem_sub : rem_sh;
         num_ff <= {num_ff[NUM_W-2:0], qbit};
      end
      if (state_ff == ST_OUT && out_free)
         rsp_gray_ff <= gray_val;
   end

   // ---------------- assertions ----------------
   a_pixel_starts: assert property (@(posedge clock) disable iff (reset)
      pix_take |=> state_ff == ST_RUN)
      else $error("pixel item accepted but sequencer did not start");

   a_oct_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> oct_ff < oct_n_ff)
      else $error("octave counter ran past the clamped count");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> maxv_ff != '0)
      else $error("divider started with zero total amplitude");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff && $stable(rsp_gray_ff))
      else $error("pending gray item was dropped or changed");

endmodule
